// ===== design/sed_pkg.sv =====
package sed_pkg;

    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X    = 8'h78;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_ESC  = 6'b000010,
        PH_OCT1 = 6'b000100,
        PH_OCT2 = 6'b001000,
        PH_HEX0 = 6'b010000,
        PH_HEX1 = 6'b100000
    } sed_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } sed_item_t;

    typedef struct packed {
        logic [1:0] count;
        sed_item_t  first;
        sed_item_t  second;
    } sed_push_t;

    function automatic logic is_oct(input logic [7:0] b);
        is_oct = (b[7:3] == 5'b00110);
    endfunction

    // Bit 4 set means the byte is a hex digit; bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            r = {1'b1, b[3:0]};
        end
        else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
        begin
            r = {1'b1, 4'(b[3:0] + 4'd9)};
        end
        hex_digit = r;
    endfunction

    function automatic logic [7:0] named_val(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            8'h61:   r = 8'd7;
            8'h62:   r = 8'd8;
            8'h66:   r = 8'd12;
            8'h6E:   r = 8'd10;
            8'h72:   r = 8'd13;
            8'h74:   r = 8'd9;
            8'h76:   r = 8'd11;
            default: r = b;
        endcase
        named_val = r;
    endfunction

endpackage

// ===== design/sed_decode.sv =====
module sed_decode
    import sed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       escapes_enabled,
    output sed_push_t  push
);

    sed_phase_t phase_reg;
    sed_phase_t phase_next;
    logic [8:0] pending_reg;
    logic [8:0] pending_next;

    logic       pre_v;
    logic [7:0] pre_b;
    logic       main_v;
    logic [7:0] main_b;
    logic       main_l;
    logic       do_plain;
    logic       oct;
    logic [4:0] hx;

    always_comb
    begin
        oct          = is_oct(in_byte);
        hx           = hex_digit(in_byte);
        phase_next   = PH_IDLE;
        pending_next = 9'd0;
        pre_v        = 1'b0;
        pre_b        = 8'd0;
        main_v       = 1'b0;
        main_b       = 8'd0;
        main_l       = 1'b0;
        do_plain     = 1'b0;

        case (phase_reg)
            PH_ESC:
            begin
                if (oct)
                begin
                    if (in_last)
                    begin
                        main_v = 1'b1;
                        main_b = {5'd0, in_byte[2:0]};
                        main_l = 1'b1;
                    end
                    else
                    begin
                        phase_next   = PH_OCT1;
                        pending_next = {6'd0, in_byte[2:0]};
                    end
                end
                else if (in_byte == CHAR_X)
                begin
                    if (in_last)
                    begin
                        main_v = 1'b1;
                        main_b = CHAR_X;
                        main_l = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_HEX0;
                    end
                end
                else
                begin
                    main_v = 1'b1;
                    main_b = named_val(in_byte);
                    main_l = in_last;
                end
            end
            PH_OCT1:
            begin
                if (oct)
                begin
                    if (in_last)
                    begin
                        main_v = 1'b1;
                        main_b = {2'd0, pending_reg[2:0], in_byte[2:0]};
                        main_l = 1'b1;
                    end
                    else
                    begin
                        phase_next   = PH_OCT2;
                        pending_next = {3'd0, pending_reg[2:0], in_byte[2:0]};
                    end
                end
                else
                begin
                    pre_v    = 1'b1;
                    pre_b    = pending_reg[7:0];
                    do_plain = 1'b1;
                end
            end
            PH_OCT2:
            begin
                if (oct)
                begin
                    main_v = 1'b1;
                    main_b = {pending_reg[4:0], in_byte[2:0]};
                    main_l = in_last;
                end
                else
                begin
                    pre_v    = 1'b1;
                    pre_b    = pending_reg[7:0];
                    do_plain = 1'b1;
                end
            end
            PH_HEX0:
            begin
                if (hx[4])
                begin
                    if (in_last)
                    begin
                        main_v = 1'b1;
                        main_b = {4'd0, hx[3:0]};
                        main_l = 1'b1;
                    end
                    else
                    begin
                        phase_next   = PH_HEX1;
                        pending_next = {5'd0, hx[3:0]};
                    end
                end
                else
                begin
                    pre_v    = 1'b1;
                    pre_b    = CHAR_X;
                    do_plain = 1'b1;
                end
            end
            PH_HEX1:
            begin
                if (hx[4])
                begin
                    main_v = 1'b1;
                    main_b = {pending_reg[3:0], hx[3:0]};
                    main_l = in_last;
                end
                else
                begin
                    pre_v    = 1'b1;
                    pre_b    = pending_reg[7:0];
                    do_plain = 1'b1;
                end
            end
            default:
            begin
                do_plain = 1'b1;
            end
        endcase

        if (do_plain)
        begin
            if (escapes_enabled && in_byte == BACKSLASH)
            begin
                if (in_last)
                begin
                    main_v = 1'b1;
                    main_b = 8'd0;
                    main_l = 1'b1;
                end
                else
                begin
                    phase_next = PH_ESC;
                end
            end
            else
            begin
                main_v = 1'b1;
                main_b = in_byte;
                main_l = in_last;
            end
        end

        push = '0;
        if (accept)
        begin
            if (pre_v)
            begin
                push.first  = '{data: pre_b, last: 1'b0};
                push.second = '{data: main_b, last: main_l};
                push.count  = {1'b0, main_v} + 2'd1;
            end
            else
            begin
                push.first = '{data: main_b, last: main_l};
                push.count = {1'b0, main_v};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            pending_reg <= 9'd0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// ===== design/sed_outq.sv =====
module sed_outq
    import sed_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  sed_push_t                  push,
    input  logic                       pop,
    output logic                       room_for_two,
    output logic                       not_empty,
    output sed_item_t                  head,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    sed_item_t       mem [DEPTH];
    logic [AW-1:0]   wr_reg;
    logic [AW-1:0]   wr_next;
    logic [AW-1:0]   wr_plus1;
    logic [AW-1:0]   rd_reg;
    logic [AW-1:0]   rd_next;
    logic [LW-1:0]   level_reg;
    logic [LW-1:0]   level_next;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_comb
    begin
        wr_plus1 = wrap_inc(wr_reg);
        case (push.count)
            2'd1:    wr_next = wr_plus1;
            2'd2:    wr_next = wrap_inc(wr_plus1);
            default: wr_next = wr_reg;
        endcase
        rd_next    = pop ? wrap_inc(rd_reg) : rd_reg;
        level_next = level_reg + LW'(push.count) - LW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            level_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            level_reg <= level_next;
        end
    end

    assign room_for_two = (level_reg <= LW'(DEPTH - 2));
    assign not_empty    = (level_reg != '0);
    assign head         = mem[rd_reg];
    assign level        = level_reg;

endmodule

// ===== design/string_escape_decoder.sv =====
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_byte[7:0], in_last
// out       output     out_valid/out_stall  out_byte[7:0], out_last
// cfg       input      cfg_valid/cfg_ready  cfg_data (escapes_enabled)
//
// One input byte is decoded per cycle while in_stall is low, yielding zero, one or two
// result bytes that enter an output queue of OUT_DEPTH entries in the same cycle.
// While out_stall is low the queue delivers one byte per cycle, the sustained rate.
// The input channel stalls while fewer than two queue entries are free.
// Reset empties the queue, clears any open escape and sets escapes_enabled to one.
module string_escape_decoder
    import sed_pkg::*;
#(
    parameter int OUT_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    localparam int LW = $clog2(OUT_DEPTH + 1);

    logic            enabled_reg;
    logic            in_xfer;
    logic            out_xfer;
    logic            room_for_two;
    sed_push_t       push;
    sed_item_t       head;
    logic [LW-1:0]   level;

    assign cfg_ready = 1'b1;
    assign in_stall  = !room_for_two;
    assign in_xfer   = in_valid && room_for_two;
    assign out_xfer  = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            enabled_reg <= cfg_data;
        end
    end

    sed_decode u_decode (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (in_xfer),
        .in_byte         (in_byte),
        .in_last         (in_last),
        .escapes_enabled (enabled_reg),
        .push            (push)
    );

    sed_outq #(
        .DEPTH (OUT_DEPTH)
    ) u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .pop          (out_xfer),
        .room_for_two (room_for_two),
        .not_empty    (out_valid),
        .head         (head),
        .level        (level)
    );

    assign out_byte = head.data;
    assign out_last = head.last;

    assert property (@(posedge clk) disable iff (!rst_n)
        level <= LW'(OUT_DEPTH))
        else $error("output queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("result dropped without a transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!in_xfer && out_xfer) |=> (level == $past(level) - LW'(1)))
        else $error("queue level wrong after a lone output transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!in_xfer && !out_xfer) |=> $stable(level))
        else $error("queue level changed without a transfer");

endmodule

// ===== bench/sed_checker.sv =====
`timescale 1ns / 100ps

module sed_checker
    import sed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte,
    input  logic       out_last,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_data,
    output int         pending_results,
    output int         results_seen,
    output int         fail_count
);

    sed_phase_t phase;
    logic [8:0] acc;
    logic       esc_en;
    sed_item_t  decoded_q [$];

    initial
    begin
        pending_results = 0;
        results_seen    = 0;
        fail_count      = 0;
    end

    function automatic logic is_octal(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h37);
    endfunction

    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            r = {1'b1, 4'(b - 8'h30)};
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        return r;
    endfunction

    function automatic logic [7:0] escape_char(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            "a":     r = 8'd7;
            "b":     r = 8'd8;
            "f":     r = 8'd12;
            "n":     r = 8'd10;
            "r":     r = 8'd13;
            "t":     r = 8'd9;
            "v":     r = 8'd11;
            default: r = b;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic push_byte(input logic [7:0] d, input logic l);
        sed_item_t it;
        it.data = d;
        it.last = l;
        decoded_q.push_back(it);
    endtask

    task automatic go_idle();
        phase = PH_IDLE;
        acc   = 9'd0;
    endtask

    task automatic take_plain(input logic [7:0] b, input logic l);
        go_idle();
        if (esc_en && b == BACKSLASH)
        begin
            if (l)
            begin
                push_byte(8'h00, 1'b1);
            end
            else
            begin
                phase = PH_ESC;
            end
        end
        else
        begin
            push_byte(b, l);
        end
    endtask

    task automatic close_escape();
        if (phase == PH_HEX0)
        begin
            push_byte(CHAR_X, 1'b1);
        end
        else
        begin
            push_byte(acc[7:0], 1'b1);
        end
        go_idle();
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic l);
        logic [4:0] hv;
        hv = hex_nibble(b);
        case (phase)
            PH_ESC:
            begin
                go_idle();
                if (is_octal(b))
                begin
                    acc   = {6'd0, b[2:0]};
                    phase = PH_OCT1;
                    if (l)
                    begin
                        close_escape();
                    end
                end
                else if (b == CHAR_X)
                begin
                    phase = PH_HEX0;
                    if (l)
                    begin
                        close_escape();
                    end
                end
                else
                begin
                    push_byte(escape_char(b), l);
                end
            end
            PH_OCT1:
            begin
                if (is_octal(b))
                begin
                    acc   = {acc[5:0], b[2:0]};
                    phase = PH_OCT2;
                    if (l)
                    begin
                        close_escape();
                    end
                end
                else
                begin
                    push_byte(acc[7:0], 1'b0);
                    take_plain(b, l);
                end
            end
            PH_OCT2:
            begin
                if (is_octal(b))
                begin
                    push_byte({acc[4:0], b[2:0]}, l);
                    go_idle();
                end
                else
                begin
                    push_byte(acc[7:0], 1'b0);
                    take_plain(b, l);
                end
            end
            PH_HEX0:
            begin
                if (hv[4])
                begin
                    acc   = {5'd0, hv[3:0]};
                    phase = PH_HEX1;
                    if (l)
                    begin
                        close_escape();
                    end
                end
                else
                begin
                    push_byte(CHAR_X, 1'b0);
                    take_plain(b, l);
                end
            end
            PH_HEX1:
            begin
                if (hv[4])
                begin
                    push_byte({acc[3:0], hv[3:0]}, l);
                    go_idle();
                end
                else
                begin
                    push_byte(acc[7:0], 1'b0);
                    take_plain(b, l);
                end
            end
            default:
            begin
                take_plain(b, l);
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sed_item_t want;
        if (!rst_n)
        begin
            go_idle();
            esc_en = 1'b1;
            decoded_q.delete();
            pending_results = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                decode_byte(in_byte, in_last);
            end
            if (cfg_valid && cfg_ready)
            begin
                esc_en = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (decoded_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected byte %02h last %0b",
                                              out_byte, out_last));
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (out_byte !== want.data)
                    begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  out_byte, want.data));
                    end
                    if (out_last !== want.last)
                    begin
                        report_mismatch($sformatf("out_last %0b, expected %0b on byte %02h",
                                                  out_last, want.last, want.data));
                    end
                end
            end
            pending_results = decoded_q.size();
        end
    end

endmodule

// ===== bench/tb_string_escape_decoder.sv =====
`timescale 1ns / 100ps

module tb_string_escape_decoder;
    import sed_pkg::*;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte   = 8'h00;
    logic       in_last   = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       out_last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;

    int pending_results;
    int results_seen;
    int fail_count;
    int bytes_sent;
    int cfg_writes;
    bit gaps_on;

    string_escape_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sed_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_byte         (in_byte),
        .in_last         (in_last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .out_last        (out_last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .pending_results (pending_results),
        .results_seen    (results_seen),
        .fail_count      (fail_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall <= gaps_on && ($urandom_range(0, 99) < 16);
    end

    initial
    begin
        #800000;
        $display("FAILURE");
        $finish;
    end

    // Called and returning at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic l);
        while (gaps_on && $urandom_range(0, 99) < 16)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_byte  = b;
        in_last  = l;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending_results != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_escapes_enabled(input logic v);
        drain();
        cfg_valid = 1'b1;
        cfg_data  = v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] named_set [7];
        logic [7:0] hex_set [22];
        int r;
        named_set = '{"a", "b", "f", "n", "r", "t", "v"};
        hex_set = '{"0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
                    "a", "b", "c", "d", "e", "f", "A", "B", "C", "D", "E", "F"};
        r = $urandom_range(0, 99);
        if (r < 18)
        begin
            return BACKSLASH;
        end
        else if (r < 32)
        begin
            return 8'(8'h30 + $urandom_range(0, 7));
        end
        else if (r < 40)
        begin
            return CHAR_X;
        end
        else if (r < 54)
        begin
            return hex_set[$urandom_range(0, 21)];
        end
        else if (r < 66)
        begin
            return named_set[$urandom_range(0, 6)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_strings(input int n_bytes);
        int sent;
        int len;
        sent = 0;
        while (sent < n_bytes)
        begin
            len = $urandom_range(1, 8);
            if ($urandom_range(0, 9) == 0)
            begin
                for (int i = 0; i < len; i++)
                begin
                    send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    sent++;
                end
            end
            else
            begin
                for (int i = 0; i < len && sent < n_bytes; i++)
                begin
                    send_byte(pick_byte(), i == len - 1);
                    sent++;
                end
            end
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], i == s.len() - 1);
        end
    endtask

    initial
    begin
        logic cfg_plan [7];
        cfg_plan   = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        bytes_sent = 0;
        cfg_writes = 0;
        gaps_on    = 1'b1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_escapes_enabled(1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_text("\\777");
        send_text("\\1z");
        send_text("\\xAf");
        send_text("\\xg");
        send_text("\\x");
        send_text("\\5");
        send_text("\\");
        send_text("\\q");

        // An escape begun before the register is cleared still completes.
        send_byte(BACKSLASH, 1'b0);
        write_escapes_enabled(1'b0);
        send_byte("n", 1'b1);
        send_byte(BACKSLASH, 1'b1);

        foreach (cfg_plan[p])
        begin
            write_escapes_enabled(cfg_plan[p]);
            gaps_on = (p != 3);
            send_strings(145);
        end
        gaps_on = 1'b1;

        drain();
        $display("Sent %0d input bytes, checked %0d decoded bytes, %0d register writes.",
                 bytes_sent, results_seen, cfg_writes);
        $display("Covered octal, hex, named and plain escapes with escapes on and off.");
        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/sed_pkg.sv
design/sed_decode.sv
design/sed_outq.sv
design/string_escape_decoder.sv
bench/sed_checker.sv
bench/tb_string_escape_decoder.sv
